// ===== rtl/box_blur_clamped_edges_top_defines.svh =====
// Assertion macros for the box blur checker.
// Needs a clk and a rst signal in the scope where a macro is used.
`ifndef BOX_BLUR_CLAMPED_EDGES_TOP_DEFINES_SVH
`define BOX_BLUR_CLAMPED_EDGES_TOP_DEFINES_SVH

// Same-cycle implication, ignored during reset
`define BBCE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("box blur check failed");

// Next-cycle implication, ignored during reset
`define BBCE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("box blur check failed");

`endif

// ===== rtl/bbce_pkg.sv =====
// Shared constants and types of the box blur block.
// No dependencies.
`default_nettype none
package bbce_pkg;
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_RADIUS  = 7;
  localparam int STORE_ROWS  = 2 * MAX_RADIUS + 1;
  localparam int STORE_DEPTH = STORE_ROWS * MAX_WIDTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COL_W       = 10;
  localparam int ROW_W       = 12;
  localparam int PIX_W       = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_BLUR_RADIUS  = 2'd2
  } cfg_idx_t;
endpackage
`default_nettype wire

// ===== rtl/bbce_if.sv =====
// Stream interfaces of the box blur block: pixel in, blurred result out.
// Depends on bbce_pkg.
`default_nettype none
interface bbce_pix_if import bbce_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  modport source (output valid, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, in_red, in_green, in_blue, output ready);
endinterface

interface bbce_res_if import bbce_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] out_column;
  logic [ROW_W-1:0] out_row;
  logic [7:0]       out_red;
  logic [7:0]       out_green;
  logic [7:0]       out_blue;
  logic             run_last;
  modport source (output valid, out_column, out_row, out_red, out_green, out_blue,
                  run_last, input ready);
  modport sink   (input valid, out_column, out_row, out_red, out_green, out_blue,
                  run_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/bbce_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bbce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/box_blur_clamped_edges_top.sv =====
// Box blur with clamp-to-edge borders: sequencer, line store and divider.
// Depends on bbce_pkg, bbce_if (interfaces) and bbce_ram.
//
// Usage: pixels of one frame enter in raster order on pix_in (valid/ready).
// Each word writes the line store (2R+1 rows of 1024 pixels). A word that
// completes the clamped window of one or more outputs releases them in
// raster order on res_out; run_last marks the last result of that word.
// Registers are written on cfg_write/cfg_index/cfg_data; the user must
// write them only while idle; the block does not enforce this. A write
// with index 0 to 2 restarts the frame at column 0, row 0.
// Timing: a result reads each of the (2R+1)^2 window taps through the
// line store port, then passes the drain state, the bit-serial divider
// and the output state; a word that releases nothing is accepted every
// cycle. The single read port of the line store and the bit-serial
// divider set the time per result. pix_in.ready is high only out of
// reset and while no result is pending. If the receiver stalls, the result
// holds on res_out and no new word is accepted. Reset clears counters and
// control and loads width 640, height 480, radius 1; the line store is not cleared.
`default_nettype none
module box_blur_clamped_edges_top import bbce_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  bbce_pix_if.sink                   pix_in,
  bbce_res_if.source                 res_out,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);
  typedef enum logic [2:0] {S_IDLE, S_READ, S_DRAIN, S_DIV, S_OUT} state_t;

  // one restoring divide step: returns {remainder, shifted quotient}
  function automatic logic [23:0] div_step(logic [15:0] q, logic [7:0] rm, logic [7:0] d);
    logic [8:0] t;
    logic [7:0] rn;
    logic       b;
    t = {rm, q[15]};
    b = (t >= {1'b0, d});
    rn = b ? 8'(t - {1'b0, d}) : t[7:0];
    return {rn, q[14:0], b};
  endfunction

  state_t           state;
  logic [10:0]      image_width;
  logic [11:0]      image_height;
  logic [2:0]       blur_radius;
  logic [COL_W-1:0] col_cnt;
  logic [ROW_W-1:0] row_cnt;
  logic [3:0]       slot_cnt;
  logic [ROW_W-1:0] win_row;
  logic [3:0]       win_slot;
  logic [COL_W-1:0] win_xlo, win_xhi, cur_x;
  logic [ROW_W-1:0] win_yhi, cur_y;
  logic [3:0]       kx, ky, div_cnt;
  logic             rd_pend;
  logic [15:0]      acc_r, acc_g, acc_b;
  logic [7:0]       rem_r, rem_g, rem_b;

  // effective configuration
  logic [10:0]      w_eff;
  logic [COL_W-1:0] wm1;
  logic [ROW_W-1:0] hm1;
  logic [3:0]       rows, rm1;
  logic [7:0]       cnt;

  always_comb begin
    if (image_width == 11'd0) w_eff = 11'd1;
    else if (image_width > 11'(MAX_WIDTH)) w_eff = 11'(MAX_WIDTH);
    else w_eff = image_width;
    wm1  = COL_W'(w_eff - 11'd1);
    hm1  = (image_height == 12'd0) ? 12'd0 : image_height - 12'd1;
    rows = {blur_radius, 1'b1};
    rm1  = {blur_radius, 1'b0};
    cnt  = {4'b0, rows} * {4'b0, rows};
  end

  // window of outputs released by the word at the current position
  logic              last_col, last_row, go;
  logic signed [11:0] xs, xlo_s, xhi_s;
  logic signed [13:0] ys, ylo_s, yhi_s;

  always_comb begin
    last_col = (col_cnt == wm1);
    last_row = (row_cnt == hm1);
    xs = $signed({2'b0, col_cnt}) - $signed({9'b0, blur_radius});
    ys = $signed({2'b0, row_cnt}) - $signed({11'b0, blur_radius});
    xlo_s = (last_col && xs < 0) ? 12'sd0 : xs;
    xhi_s = last_col ? $signed({2'b0, col_cnt}) : xs;
    ylo_s = (last_row && ys < 0) ? 14'sd0 : ys;
    yhi_s = last_row ? $signed({2'b0, row_cnt}) : ys;
    go = !xlo_s[11] && !ylo_s[13];
  end

  // line store read address for window tap (kx, ky) of output (cur_x, cur_y)
  logic signed [11:0] xx_s;
  logic signed [13:0] yy_s;
  logic [COL_W-1:0]   xx;
  logic [ROW_W-1:0]   yy, row_back;
  logic signed [4:0]  slot_s;
  logic [3:0]         slot;
  logic [ADDR_W-1:0]  raddr;

  always_comb begin
    xx_s = $signed({2'b0, cur_x}) + $signed({8'b0, kx}) - $signed({9'b0, blur_radius});
    yy_s = $signed({2'b0, cur_y}) + $signed({10'b0, ky}) - $signed({11'b0, blur_radius});
    if (xx_s < 0) xx = '0;
    else if (xx_s > $signed({2'b0, wm1})) xx = wm1;
    else xx = xx_s[COL_W-1:0];
    if (yy_s < 0) yy = '0;
    else if (yy_s > $signed({2'b0, hm1})) yy = hm1;
    else yy = yy_s[ROW_W-1:0];
    row_back = win_row - yy;
    slot_s   = $signed({1'b0, win_slot}) - $signed({1'b0, row_back[3:0]});
    slot     = (slot_s < 0) ? 4'(slot_s + $signed({1'b0, rows})) : slot_s[3:0];
    raddr    = {slot, xx};
  end

  logic              accept;
  logic [PIX_W-1:0]  rdata;

  assign accept       = pix_in.valid && pix_in.ready;
  assign pix_in.ready = (state == S_IDLE) && !rst;

  bbce_ram #(.WIDTH(PIX_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (accept),
    .waddr ({slot_cnt, col_cnt}),
    .wdata ({pix_in.in_red, pix_in.in_green, pix_in.in_blue}),
    .raddr (raddr),
    .rdata (rdata)
  );

  logic [23:0] st_r, st_g, st_b;
  assign st_r = div_step(acc_r, rem_r, cnt);
  assign st_g = div_step(acc_g, rem_g, cnt);
  assign st_b = div_step(acc_b, rem_b, cnt);

  // sequencer, counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      image_width  <= 11'd640;
      image_height <= 12'd480;
      blur_radius  <= 3'd1;
      col_cnt      <= '0;
      row_cnt      <= '0;
      slot_cnt     <= '0;
      rd_pend      <= 1'b0;
    end else begin
      rd_pend <= (state == S_READ);
      if (rd_pend) begin
        acc_r <= acc_r + 16'(rdata[23:16]);
        acc_g <= acc_g + 16'(rdata[15:8]);
        acc_b <= acc_b + 16'(rdata[7:0]);
      end
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_IMAGE_WIDTH: image_width  <= cfg_data[10:0];
          CFG_IMAGE_HEIGHT: image_height <= cfg_data[11:0];
          CFG_BLUR_RADIUS: blur_radius  <= cfg_data[2:0];
          default: ;
        endcase
        if (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT ||
            cfg_index == CFG_BLUR_RADIUS) begin
          col_cnt  <= '0;
          row_cnt  <= '0;
          slot_cnt <= '0;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            win_row  <= row_cnt;
            win_slot <= slot_cnt;
            win_xlo  <= xlo_s[COL_W-1:0];
            win_xhi  <= xhi_s[COL_W-1:0];
            win_yhi  <= yhi_s[ROW_W-1:0];
            cur_x    <= xlo_s[COL_W-1:0];
            cur_y    <= ylo_s[ROW_W-1:0];
            kx       <= '0;
            ky       <= '0;
            acc_r    <= '0;
            acc_g    <= '0;
            acc_b    <= '0;
            if (go) state <= S_READ;
            // advance the raster position
            if (last_col) begin
              col_cnt <= '0;
              if (last_row) begin
                row_cnt  <= '0;
                slot_cnt <= '0;
              end else begin
                row_cnt  <= row_cnt + 12'd1;
                slot_cnt <= (slot_cnt == rm1) ? 4'd0 : slot_cnt + 4'd1;
              end
            end else begin
              col_cnt <= col_cnt + 10'd1;
            end
          end
        end
        S_READ: begin
          if (kx == rm1) begin
            kx <= '0;
            ky <= ky + 4'd1;
            if (ky == rm1) state <= S_DRAIN;
          end else begin
            kx <= kx + 4'd1;
          end
        end
        S_DRAIN: begin
          div_cnt <= '0;
          rem_r   <= '0;
          rem_g   <= '0;
          rem_b   <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          {rem_r, acc_r} <= st_r;
          {rem_g, acc_g} <= st_g;
          {rem_b, acc_b} <= st_b;
          div_cnt <= div_cnt + 4'd1;
          if (div_cnt == 4'd15) state <= S_OUT;
        end
        S_OUT: begin
          if (res_out.ready) begin
            if (res_out.run_last) begin
              state <= S_IDLE;
            end else begin
              if (cur_x == win_xhi) begin
                cur_x <= win_xlo;
                cur_y <= cur_y + 12'd1;
              end else begin
                cur_x <= cur_x + 10'd1;
              end
              kx    <= '0;
              ky    <= '0;
              acc_r <= '0;
              acc_g <= '0;
              acc_b <= '0;
              state <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res_out.valid      = (state == S_OUT);
  assign res_out.out_column = cur_x;
  assign res_out.out_row    = cur_y;
  assign res_out.out_red    = acc_r[7:0];
  assign res_out.out_green  = acc_g[7:0];
  assign res_out.out_blue   = acc_b[7:0];
  assign res_out.run_last   = (cur_x == win_xhi) && (cur_y == win_yhi);
endmodule
`default_nettype wire

// ===== rtl/bbce_checker.sv =====
// Port-level checks of the box blur top level, attached by bind.
// Depends on box_blur_clamped_edges_top_defines.svh.
`default_nettype none
`include "box_blur_clamped_edges_top_defines.svh"
module bbce_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_last
);
  // a stalled result stays offered
  `BBCE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // no word is taken while a result is pending
  `BBCE_ASSERT_NOW(a_busy_excl, out_valid, !in_ready)
  // more results of the same word follow a non-last one
  `BBCE_ASSERT_NEXT(a_run_cont, out_valid && out_ready && !out_last, !in_ready)
  // results end with the last of the run before a new word
  `BBCE_ASSERT_NEXT(a_run_end, out_valid && out_ready && out_last, in_ready && !out_valid)
endmodule

bind box_blur_clamped_edges_top bbce_checker u_bbce_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pix_in.ready),
  .out_valid (res_out.valid),
  .out_ready (res_out.ready),
  .out_last  (res_out.run_last)
);
`default_nettype wire

// ===== bench/box_blur_clamped_edges_top_test.sv =====
// Testbench for the clamp-to-edge box blur: directed and random frames checked
// against a cycle-free predictor. Needs bbce_pkg, bbce_if and the top module.
`default_nettype none
module box_blur_clamped_edges_top_test;
  import bbce_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             last;
  } blur_word_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bbce_pix_if pix ();
  bbce_res_if res ();

  box_blur_clamped_edges_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .pix_in   (pix),
    .res_out  (res),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow of the block: line store, raster position and registers
  logic [PIX_W-1:0] shadow_store [STORE_DEPTH];
  int               frame_col, frame_row;
  int               reg_width, reg_height, reg_radius;
  blur_word_t       pending_means[$];

  int sender_gap_pct, receiver_stall_pct;
  int errors, pixels_sent, words_checked, cfg_writes;

  function automatic int width_now();
    if (reg_width == 0) return 1;
    if (reg_width > MAX_WIDTH) return MAX_WIDTH;
    return reg_width;
  endfunction

  function automatic int height_now();
    return (reg_height == 0) ? 1 : reg_height;
  endfunction

  function automatic int clamp_int(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // Truncated window mean around (x,y), clamped to the image
  function automatic blur_word_t window_mean(int x, int y, int w, int h, int rad);
    int sr, sg, sb, nrows, yy, xx;
    logic [PIX_W-1:0] p;
    blur_word_t o;
    sr = 0; sg = 0; sb = 0;
    nrows = 2 * rad + 1;
    for (int dy = -rad; dy <= rad; dy++) begin
      yy = clamp_int(y + dy, h - 1);
      for (int dx = -rad; dx <= rad; dx++) begin
        xx = clamp_int(x + dx, w - 1);
        p = shadow_store[(yy % nrows) * MAX_WIDTH + xx];
        sr += p[23:16];
        sg += p[15:8];
        sb += p[7:0];
      end
    end
    o.col   = x[COL_W-1:0];
    o.row   = y[ROW_W-1:0];
    o.red   = 8'(sr / (nrows * nrows));
    o.green = 8'(sg / (nrows * nrows));
    o.blue  = 8'(sb / (nrows * nrows));
    o.last  = 1'b0;
    return o;
  endfunction

  // Store one accepted pixel and queue every mean it releases
  task automatic predict_pixel(logic [PIX_W-1:0] p);
    int w, h, rad, xlo, xhi, ylo, yhi, n;
    blur_word_t o;
    w = width_now();
    h = height_now();
    rad = reg_radius;
    n = 0;
    shadow_store[(frame_row % (2 * rad + 1)) * MAX_WIDTH + frame_col] = p;
    if (frame_col == w - 1) begin
      xlo = (frame_col - rad < 0) ? 0 : frame_col - rad;
      xhi = frame_col;
    end else begin
      xlo = frame_col - rad;
      xhi = xlo;
    end
    if (frame_row == h - 1) begin
      ylo = (frame_row - rad < 0) ? 0 : frame_row - rad;
      yhi = frame_row;
    end else begin
      ylo = frame_row - rad;
      yhi = ylo;
    end
    if (xlo >= 0 && ylo >= 0) begin
      for (int y = ylo; y <= yhi; y++)
        for (int x = xlo; x <= xhi; x++) begin
          o = window_mean(x, y, w, h, rad);
          o.last = (y == yhi) && (x == xhi);
          pending_means.push_back(o);
        end
    end
    if (frame_col >= w - 1) begin
      frame_col = 0;
      frame_row = (frame_row >= h - 1) ? 0 : frame_row + 1;
    end else begin
      frame_col++;
    end
  endtask

  // Send one pixel word; valid stays high for a following word
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    if ($urandom_range(99) < sender_gap_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_gap_pct) @(posedge clk);
    end
    pix.valid    <= 1'b1;
    pix.in_red   <= r;
    pix.in_green <= g;
    pix.in_blue  <= b;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    predict_pixel({r, g, b});
    pixels_sent++;
  endtask

  task automatic send_random_pixel();
    send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Wait for all queued means, then for one worst-case result time
  task automatic drain();
    pix.valid <= 1'b0;
    @(posedge clk);
    while (pending_means.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Register write while idle; any write restarts the frame
  task automatic write_reg(cfg_idx_t idx, int value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_IMAGE_WIDTH:  reg_width  = value & 'h7FF;
      CFG_IMAGE_HEIGHT: reg_height = value & 'hFFF;
      CFG_BLUR_RADIUS:  reg_radius = value & 'h7;
      default: ;
    endcase
    frame_col = 0;
    frame_row = 0;
    cfg_writes++;
  endtask

  task automatic set_frame(int w, int h, int rad);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_BLUR_RADIUS, rad);
  endtask

  // Receiver stalls at random
  always @(posedge clk) begin
    if (rst) res.ready <= 1'b0;
    else res.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Compare each result word with the oldest expected mean
  always @(posedge clk) begin
    blur_word_t want, got;
    if (!rst && res.valid && res.ready) begin
      got = '{res.out_column, res.out_row, res.out_red, res.out_green, res.out_blue,
              res.run_last};
      if (pending_means.size() == 0) begin
        $display("%0t: result with nothing expected, actual %p", $time, got);
        errors++;
      end else begin
        want = pending_means.pop_front();
        words_checked++;
        if (got !== want) begin
          $display("%0t: mismatch, expected %p actual %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  // Reset defaults, register extremes and out-of-range register values
  task automatic test_directed();
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd255);
    drain();
    set_frame(1, 1, 0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd0, 8'd0, 8'd0);
    drain();
    // zero width and height act as one
    set_frame(0, 0, 7);
    send_pixel(8'd170, 8'd85, 8'd1);
    drain();
    set_frame(3, 2, 1);
    for (int i = 0; i < 6; i++)
      send_pixel(i[0] ? 8'd255 : 8'd0, i[0] ? 8'd0 : 8'd255, 8'(i * 51));
    drain();
    // oversize width acts as the maximum; tallest frame
    set_frame(2047, 4095, 0);
    for (int i = 0; i < 3; i++) send_random_pixel();
    drain();
    set_frame(1024, 1, 0);
    send_pixel(8'd128, 8'd127, 8'd254);
    drain();
  endtask

  // Small random frames, mostly whole, some cut short by a register write
  task automatic test_random_frames(int budget);
    int w, h, rad, n;
    while (budget > 0) begin
      w = $urandom_range(10, 1);
      h = $urandom_range(8, 1);
      rad = $urandom_range(7, 0);
      if ($urandom_range(9) == 0) begin
        w = 8;
        h = 8;
        rad = 7;
      end
      set_frame(w, h, rad);
      n = w * h;
      if ($urandom_range(7) == 0) n = $urandom_range(n, 1);
      for (int i = 0; i < n; i++) send_random_pixel();
      // sometimes run a second frame with the same settings
      if ($urandom_range(3) == 0 && n == w * h) begin
        for (int i = 0; i < n; i++) send_random_pixel();
        n = 2 * n;
      end
      drain();
      budget -= n;
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_data  <= '0;
    pix.valid <= 1'b0;
    pix.in_red <= '0;
    pix.in_green <= '0;
    pix.in_blue <= '0;
    reg_width = 640;
    reg_height = 480;
    reg_radius = 1;
    frame_col = 0;
    frame_row = 0;
    errors = 0;
    pixels_sent = 0;
    words_checked = 0;
    cfg_writes = 0;
    sender_gap_pct = 0;
    receiver_stall_pct = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    sender_gap_pct = 9;
    receiver_stall_pct = 64;
    test_directed();
    test_random_frames(90);
    sender_gap_pct = 64;
    receiver_stall_pct = 9;
    test_random_frames(90);
    sender_gap_pct = 0;
    receiver_stall_pct = 0;
    test_random_frames(90);
    drain();

    $display("Covered %0d pixels, %0d blurred words, %0d register writes,", pixels_sent,
             words_checked, cfg_writes);
    $display("radius 0..7, widths 0..2047, heights 0..4095, three idle patterns.");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/bbce_pkg.sv
rtl/bbce_if.sv
rtl/bbce_ram.sv
rtl/box_blur_clamped_edges_top.sv
rtl/bbce_checker.sv
bench/box_blur_clamped_edges_top_test.sv
